// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the modules of the isodensity crossing core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ICC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("icc assertion failed");

// Condition must never be true outside reset.
`define ICC_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("icc forbidden condition seen");

`endif

// File: hw/rtl/icc_pkg.sv
// Types and constants shared by the isodensity crossing core.
package icc_pkg;

   localparam int DATA_W   = 32;
   localparam int ZSTEP_W  = 24;
   localparam int HEIGHT_W = 32;
   localparam int PROD_W   = DATA_W + ZSTEP_W;
   localparam int QUOT_W   = ZSTEP_W;
   localparam int DIVCNT_W = $clog2(QUOT_W);
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [ZSTEP_W-1:0]  ZSTEP_RESET    = ZSTEP_W'(65536);
   localparam logic [DIVCNT_W-1:0] DIV_LAST_STEP  = DIVCNT_W'(QUOT_W - 1);

   // Register index, taken from the word address bit of paddr.
   localparam logic CSR_IDX_THRESHOLD = 1'b0;
   localparam logic CSR_IDX_ZSTEP     = 1'b1;

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   typedef struct packed {
      logic [DATA_W-1:0]  threshold;
      logic [ZSTEP_W-1:0] z_step;
   } icc_cfg_type;

   // One job for the back end: an optional crossing and an optional column end.
   typedef struct packed {
      logic               has_cross;
      logic               to_upper;
      logic               is_end;
      logic               rise_seen;
      logic               fall_seen;
      logic [DATA_W-1:0]  num;
      logic [DATA_W-1:0]  den;
      logic [ZSTEP_W-1:0] zs;
   } icc_job_type;

   localparam int JOB_W = $bits(icc_job_type);

endpackage

// File: hw/rtl/icc_if.sv
// Stream interfaces for the sample words and the result words.
interface icc_req_if;
   import icc_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] density;
   logic              last;

   modport source (output valid, density, last, input ready);
   modport sink   (input valid, density, last, output ready);
endinterface

interface icc_rsp_if;
   import icc_pkg::*;
   logic                valid;
   logic                ready;
   logic [HEIGHT_W-1:0] bottom_height;
   logic [HEIGHT_W-1:0] top_height;
   logic                bottom_found;
   logic                top_found;

   modport source (output valid, bottom_height, top_height, bottom_found, top_found,
                   input ready);
   modport sink   (input valid, bottom_height, top_height, bottom_found, top_found,
                   output ready);
endinterface

// File: hw/rtl/icc_csr.sv
// Configuration registers: threshold and z step, written over the APB-style port.
module icc_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  icc_pkg::csr_addr_type csr_paddr,
   input  icc_pkg::csr_data_type csr_pwdata,
   output icc_pkg::csr_data_type csr_prdata,
   output logic                 csr_pready,
   output icc_pkg::icc_cfg_type cfg
);
   import icc_pkg::*;

   logic [DATA_W-1:0]  threshold_ff, threshold_in;
   logic [ZSTEP_W-1:0] zstep_ff, zstep_in;
   logic               write;
   logic               reg_idx;

   // Registers sit on 32-bit word boundaries; the byte offset bits are ignored.
   assign reg_idx    = csr_paddr[2];
   assign write      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      threshold_in = threshold_ff;
      zstep_in     = zstep_ff;
      if (write) begin
         case (reg_idx)
            CSR_IDX_THRESHOLD: threshold_in = csr_pwdata;
            CSR_IDX_ZSTEP:     zstep_in     = csr_pwdata[ZSTEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         CSR_IDX_THRESHOLD: csr_prdata = threshold_ff;
         CSR_IDX_ZSTEP:     csr_prdata = {{(CSR_DATA_W-ZSTEP_W){1'b0}}, zstep_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         zstep_ff     <= ZSTEP_RESET;
      end else begin
         threshold_ff <= threshold_in;
         zstep_ff     <= zstep_in;
      end
   end

   assign cfg.threshold = threshold_ff;
   assign cfg.z_step    = zstep_ff;

endmodule

// File: hw/rtl/icc_front.sv
// Front end: takes sample words, tracks the column state and classifies crossings.
`include "assert_macros.svh"
module icc_front #(
   parameter int COLUMN_DEPTH = 256,
   parameter int IDX_W        = $clog2(COLUMN_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  icc_pkg::icc_cfg_type cfg,
   icc_req_if.sink              req_ch,
   input  logic                 q_full,
   output logic                 q_push,
   output icc_pkg::icc_job_type q_job,
   output logic [IDX_W-1:0]     q_k
);
   import icc_pkg::*;

   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(COLUMN_DEPTH - 1);

   logic [DATA_W-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              starts_low_ff, starts_low_in;
   logic              rise_seen_ff, rise_seen_in;
   logic              fall_seen_ff, fall_seen_in;

   logic              accept;
   logic              first;
   logic              rise, fall;
   logic              set_lower, set_upper;
   logic              rise_now, fall_now;
   logic [DATA_W-1:0] d, thr;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign d            = req_ch.density;
   assign thr          = cfg.threshold;
   assign first        = (idx_ff == '0);
   assign rise         = (prev_ff < thr) && (d > thr);
   assign fall         = (prev_ff > thr) && (d < thr);

   always_comb begin
      set_lower = 1'b0;
      set_upper = 1'b0;
      if (!first) begin
         if (starts_low_ff) begin
            set_lower = rise && !rise_seen_ff;
            set_upper = fall && rise_seen_ff;
         end else begin
            set_upper = fall && !fall_seen_ff;
            set_lower = rise && fall_seen_ff;
         end
      end
   end

   assign rise_now = rise_seen_ff | set_lower;
   assign fall_now = fall_seen_ff | set_upper;

   always_comb begin
      q_job.has_cross = set_lower | set_upper;
      q_job.to_upper  = set_upper;
      q_job.is_end    = req_ch.last;
      q_job.rise_seen = rise_now;
      q_job.fall_seen = fall_now;
      q_job.zs        = cfg.z_step;
      if (prev_ff < d) begin
         q_job.num = thr - prev_ff;
         q_job.den = d - prev_ff;
      end else begin
         q_job.num = prev_ff - thr;
         q_job.den = prev_ff - d;
      end
   end

   assign q_k    = idx_ff - IDX_W'(1);
   assign q_push = accept && (set_lower || set_upper || req_ch.last);

   always_comb begin
      prev_in       = prev_ff;
      idx_in        = idx_ff;
      starts_low_in = starts_low_ff;
      rise_seen_in  = rise_seen_ff;
      fall_seen_in  = fall_seen_ff;
      if (accept) begin
         if (req_ch.last) begin
            prev_in       = '0;
            idx_in        = '0;
            starts_low_in = 1'b0;
            rise_seen_in  = 1'b0;
            fall_seen_in  = 1'b0;
         end else begin
            prev_in      = d;
            rise_seen_in = rise_now;
            fall_seen_in = fall_now;
            if (first) begin
               starts_low_in = d < thr;
            end
            if (idx_ff != IDX_MAX) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '0;
         idx_ff        <= '0;
         starts_low_ff <= 1'b0;
         rise_seen_ff  <= 1'b0;
         fall_seen_ff  <= 1'b0;
      end else begin
         prev_ff       <= prev_in;
         idx_ff        <= idx_in;
         starts_low_ff <= starts_low_in;
         rise_seen_ff  <= rise_seen_in;
         fall_seen_ff  <= fall_seen_in;
      end
   end

   // A fresh column has no crossings recorded yet.
   `ICC_ASSERT(a_fresh_column_clear, clock, reset, (idx_ff == '0) |-> (!rise_seen_ff && !fall_seen_ff))

endmodule

// File: hw/rtl/icc_queue.sv
// Short job queue between the front end and the divider back end.
`include "assert_macros.svh"
module icc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             valid
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_FULL);
   assign valid    = (cnt_ff != '0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   `ICC_ASSERT_NEVER(a_no_overflow, clock, reset, push && full)
   `ICC_ASSERT_NEVER(a_no_underflow, clock, reset, pop && !valid)

endmodule

// File: hw/rtl/icc_back.sv
// Back end: interpolates crossing heights with a serial divider and emits results.
`include "assert_macros.svh"
module icc_back #(
   parameter int IDX_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  icc_pkg::icc_job_type q_job,
   input  logic [IDX_W-1:0]     q_k,
   output logic                 q_pop,
   icc_rsp_if.source            rsp_ch
);
   import icc_pkg::*;

   localparam int BASE_W = IDX_W + ZSTEP_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_ADD  = 5'b01000,
      ST_OUT  = 5'b10000
   } back_state_type;

   back_state_type      state_ff, state_in;
   icc_job_type         job_ff, job_in;
   logic [IDX_W-1:0]    k_ff, k_in;
   logic [DATA_W-1:0]   rem_ff, rem_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [DIVCNT_W-1:0] cnt_ff, cnt_in;
   logic [HEIGHT_W-1:0] lower_ff, lower_in;
   logic [HEIGHT_W-1:0] upper_ff, upper_in;

   logic [PROD_W-1:0]   prod;
   logic [DATA_W:0]     trial;
   logic                fits;
   logic [63:0]         sum;
   logic [HEIGHT_W-1:0] height;

   assign prod   = job_ff.zs * job_ff.num;
   // The dividend shifts in one bit per step below the running remainder.
   assign trial  = {rem_ff, quot_ff[QUOT_W-1]};
   assign fits   = trial >= {1'b0, job_ff.den};
   assign sum    = 64'(base_ff) + 64'(quot_ff);
   assign height = (sum[63:HEIGHT_W] != '0) ? '1 : sum[HEIGHT_W-1:0];

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      k_in     = k_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      base_in  = base_ff;
      cnt_in   = cnt_ff;
      lower_in = lower_ff;
      upper_in = upper_ff;
      q_pop    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               job_in   = q_job;
               k_in     = q_k;
               state_in = q_job.has_cross ? ST_MUL : ST_OUT;
            end
         end
         ST_MUL: begin
            // Quotient is below z_step, so the top bits already sit under the divisor.
            rem_in   = prod[PROD_W-1:QUOT_W];
            quot_in  = prod[QUOT_W-1:0];
            base_in  = k_ff * job_ff.zs;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = fits ? DATA_W'(trial - {1'b0, job_ff.den}) : trial[DATA_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], fits};
            cnt_in  = cnt_ff + DIVCNT_W'(1);
            if (cnt_ff == DIV_LAST_STEP) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (job_ff.to_upper) begin
               upper_in = height;
            end else begin
               lower_in = height;
            end
            state_in = job_ff.is_end ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               lower_in = '0;
               upper_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      k_ff    <= k_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      base_ff <= base_in;
      cnt_ff  <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lower_ff <= '0;
         upper_ff <= '0;
      end else begin
         state_ff <= state_in;
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

   assign rsp_ch.valid         = (state_ff == ST_OUT);
   assign rsp_ch.bottom_height = lower_ff;
   assign rsp_ch.top_height    = upper_ff;
   assign rsp_ch.bottom_found  = job_ff.rise_seen;
   assign rsp_ch.top_found     = job_ff.fall_seen;

   // A strict crossing always has distinct neighbors, so the divisor is never zero.
   `ICC_ASSERT(a_den_nonzero, clock, reset, (state_ff == ST_DIV) |-> (job_ff.den != '0))
   // The interpolated fraction of a bin stays below one bin height.
   `ICC_ASSERT(a_quot_bound, clock, reset, (state_ff == ST_ADD) |-> ((quot_ff == '0) || (quot_ff < job_ff.zs)))

endmodule

// File: hw/rtl/isodensity_column_crossing_core.sv
// Isodensity column crossing finder: top level joining registers, front end, queue and back end.
//
// Density samples of one z column arrive in order on req_ch, with last marking the final one;
// for each column one result word leaves on rsp_ch with the bottom and top surface heights in
// unsigned 16.16, each found by linear interpolation between the two bins around a threshold
// crossing and saturated at all ones, plus a found flag for each. The front end takes one
// sample per cycle as long as the job queue (QUEUE_DEPTH entries) has room; only samples whose
// crossing sets a surface, or that end a column, enter the queue. The back end works on one
// job at a time: queue pop, multiply, a radix-2 restoring divider and an add and saturate step
// for a crossing; for a column end it then holds the result word in its output registers until
// rsp_ch takes it, while the front end keeps taking samples as long as the queue has room. The
// divider is the limiting unit: a column with few crossings runs at one sample per cycle, and a
// steady stream of crossings fills the queue and stalls req_ch. Threshold sits at byte address 0
// and z_step at 4 on the csr_ port.
module isodensity_column_crossing_core #(
   parameter int COLUMN_DEPTH = 256,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   icc_req_if.sink               req_ch,
   icc_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  icc_pkg::csr_addr_type csr_paddr,
   input  icc_pkg::csr_data_type csr_pwdata,
   output icc_pkg::csr_data_type csr_prdata,
   output logic                  csr_pready
);
   import icc_pkg::*;

   localparam int IDX_W   = $clog2(COLUMN_DEPTH);
   localparam int QUEUE_W = JOB_W + IDX_W;

   icc_cfg_type        cfg;
   icc_job_type        push_job, pop_job;
   logic [IDX_W-1:0]   push_k, pop_k;
   logic               q_push, q_pop, q_full, q_valid;
   logic [QUEUE_W-1:0] push_data, pop_data;

   icc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   icc_front #(
      .COLUMN_DEPTH (COLUMN_DEPTH),
      .IDX_W        (IDX_W)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (push_job),
      .q_k    (push_k)
   );

   assign push_data = {push_job, push_k};

   icc_queue #(
      .WIDTH (QUEUE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .valid     (q_valid)
   );

   assign pop_job = icc_job_type'(pop_data[QUEUE_W-1:IDX_W]);
   assign pop_k   = pop_data[IDX_W-1:0];

   icc_back #(
      .IDX_W (IDX_W)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (pop_job),
      .q_k     (pop_k),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the isodensity column crossing core.
module tb;
   import icc_pkg::*;

   localparam int unsigned COLUMN_DEPTH  = 256;
   localparam int unsigned SETTLE_CYCLES = 200;
   localparam int unsigned RUN_LIMIT     = 8 * 600_000;

   localparam csr_addr_type THRESHOLD_ADDR = {CSR_IDX_THRESHOLD, 2'b00};
   localparam csr_addr_type ZSTEP_ADDR     = {CSR_IDX_ZSTEP, 2'b00};

   typedef struct packed {
      logic [HEIGHT_W-1:0] bottom_height;
      logic [HEIGHT_W-1:0] top_height;
      logic                bottom_found;
      logic                top_found;
   } surfaces_type;

   // Tracks one column at a time and keeps the surface words still owed by the block.
   class surface_tracker_type #(int unsigned DEPTH = 256);
      logic [DATA_W-1:0]   threshold = '0;
      logic [ZSTEP_W-1:0]  z_step = ZSTEP_RESET;
      logic [DATA_W-1:0]   prev_density = '0;
      int unsigned         bin = 0;
      bit                  starts_low = 0;
      bit                  rise_seen = 0;
      bit                  fall_seen = 0;
      logic [HEIGHT_W-1:0] lower_surface = '0;
      logic [HEIGHT_W-1:0] upper_surface = '0;
      surfaces_type        pending[$];
      int unsigned         mismatches = 0;

      function logic [HEIGHT_W-1:0] interp_height(int unsigned k, logic [DATA_W-1:0] h0,
                                                  logic [DATA_W-1:0] h1);
         logic [63:0] num;
         logic [63:0] den;
         logic [63:0] v;
         if (h0 < h1) begin
            num = 64'(threshold) - 64'(h0);
            den = 64'(h1) - 64'(h0);
         end else begin
            num = 64'(h0) - 64'(threshold);
            den = 64'(h0) - 64'(h1);
         end
         v = 64'(k) * 64'(z_step);
         if (den != 0)
            v += (64'(z_step) * num) / den;
         if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
         return v[HEIGHT_W-1:0];
      endfunction

      function void take_sample(logic [DATA_W-1:0] density, logic last);
         bit rise;
         bit fall;
         int unsigned k;
         if (bin == 0) begin
            starts_low = density < threshold;
         end else begin
            k = bin - 1;
            rise = (prev_density < threshold) && (density > threshold);
            fall = (prev_density > threshold) && (density < threshold);
            // The mode picks which surface takes the first crossing only and which
            // one keeps being overwritten by later crossings.
            if (starts_low) begin
               if (rise && !rise_seen) begin
                  lower_surface = interp_height(k, prev_density, density);
                  rise_seen = 1;
               end
               if (fall && rise_seen) begin
                  upper_surface = interp_height(k, prev_density, density);
                  fall_seen = 1;
               end
            end else begin
               if (fall && !fall_seen) begin
                  upper_surface = interp_height(k, prev_density, density);
                  fall_seen = 1;
               end
               if (rise && fall_seen) begin
                  lower_surface = interp_height(k, prev_density, density);
                  rise_seen = 1;
               end
            end
         end
         prev_density = density;
         if (bin < DEPTH - 1)
            bin++;
         if (last) begin
            pending.insert(pending.size(),
                           surfaces_type'{lower_surface, upper_surface, rise_seen, fall_seen});
            prev_density = '0;
            bin = 0;
            starts_low = 0;
            rise_seen = 0;
            fall_seen = 0;
            lower_surface = '0;
            upper_surface = '0;
         end
      endfunction

      function void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
      endfunction

      function void match_surfaces(surfaces_type got);
         surfaces_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result word with nothing pending: bottom %h top %h flags %b%b",
                        got.bottom_height, got.top_height, got.bottom_found, got.top_found);
            return;
         end
         want = pending.pop_front();
         if (got.bottom_height !== want.bottom_height)
            flag_mismatch("bottom_height", want.bottom_height, got.bottom_height);
         if (got.top_height !== want.top_height)
            flag_mismatch("top_height", want.top_height, got.top_height);
         if (got.bottom_found !== want.bottom_found)
            flag_mismatch("bottom_found", 32'(want.bottom_found), 32'(got.bottom_found));
         if (got.top_found !== want.top_found)
            flag_mismatch("top_found", 32'(want.top_found), 32'(got.top_found));
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   csr_addr_type csr_paddr;
   csr_data_type csr_pwdata;
   csr_data_type csr_prdata;
   logic         csr_pready;

   icc_req_if req_ch();
   icc_rsp_if rsp_ch();

   surface_tracker_type #(COLUMN_DEPTH) sb = new;
   int unsigned samples_sent = 0;
   bit          calm = 0;

   isodensity_column_crossing_core #(.COLUMN_DEPTH(COLUMN_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   initial begin
      #(RUN_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // Result side back-pressure: random stall bursts until the final phase.
   initial begin : rsp_stall
      int unsigned n;
      rsp_ch.ready = 1'b0;
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 16);
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         n = $urandom_range(1, 16);
         repeat (n) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.match_surfaces(surfaces_type'{rsp_ch.bottom_height, rsp_ch.top_height,
                                          rsp_ch.bottom_found, rsp_ch.top_found});
   end

   task automatic csr_write(csr_addr_type addr, csr_data_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(csr_addr_type addr, output csr_data_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic verify_settings();
      csr_data_type got;
      csr_read(THRESHOLD_ADDR, got);
      if (got !== sb.threshold)
         sb.flag_mismatch("threshold readback", sb.threshold, got);
      csr_read(ZSTEP_ADDR, got);
      if (got !== 32'(sb.z_step))
         sb.flag_mismatch("z_step readback", 32'(sb.z_step), got);
   endtask

   // The upper byte of the z_step word may hold junk; only 24 bits are kept.
   task automatic apply_settings(logic [DATA_W-1:0] thr, logic [31:0] zs_word);
      csr_write(THRESHOLD_ADDR, thr);
      sb.threshold = thr;
      csr_write(ZSTEP_ADDR, zs_word);
      sb.z_step = zs_word[ZSTEP_W-1:0];
      verify_settings();
   endtask

   task automatic send_sample(logic [DATA_W-1:0] d, logic lst);
      req_ch.valid   <= 1'b1;
      req_ch.density <= d;
      req_ch.last    <= lst;
      do @(posedge clock); while (!req_ch.ready);
      sb.take_sample(d, lst);
      samples_sent++;
   endtask

   task automatic hold_off(int unsigned n);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Waits until every column word has come back, then idles for SETTLE_CYCLES.
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_density(bit above);
      logic [DATA_W-1:0] thr;
      logic [DATA_W-1:0] span;
      thr = sb.threshold;
      if ($urandom_range(0, 19) == 0)
         return above ? 32'hFFFF_FFFF : 32'h0;
      if (above) begin
         if (thr == 32'hFFFF_FFFF)
            return thr;
         span = 32'hFFFF_FFFF - thr;
         if ($urandom_range(0, 1))
            return thr + $urandom_range(1, span < 16 ? span : 16);
         return $urandom_range(thr + 1, 32'hFFFF_FFFF);
      end
      if (thr == 0)
         return thr;
      if ($urandom_range(0, 1))
         return thr - $urandom_range(1, thr < 16 ? thr : 16);
      return $urandom_range(0, thr - 1);
   endfunction

   // Samples wander across the threshold so most columns hold real crossings.
   task automatic send_column(int unsigned len);
      bit                above;
      int unsigned       pick;
      logic [DATA_W-1:0] d;
      above = $urandom_range(0, 1);
      for (int unsigned i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)
            above = !above;
         if (pick >= 90 && pick < 95)
            d = sb.threshold;
         else if (pick >= 95)
            d = $urandom;
         else
            d = pick_density(above);
         if (!calm && $urandom_range(0, 9) == 0)
            hold_off($urandom_range(1, 16));
         send_sample(d, i == len - 1);
      end
   endtask

   initial begin : stimulus
      logic [DATA_W-1:0] thr;
      logic [31:0]       zs;
      int unsigned       budget;
      int unsigned       phase_start;
      int unsigned       len;
      req_ch.valid   = 1'b0;
      req_ch.density = '0;
      req_ch.last    = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      reset          = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      verify_settings();

      // Reset settings: a threshold of zero leaves nothing below it.
      send_sample(32'h0, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0, 1'b1);
      drain_block();

      apply_settings(32'd1000, 32'h0001_0000);
      send_sample(32'd500, 1'b1);
      // Starts low: a rise sets the bottom, a fall sets the top.
      send_sample(32'd0, 1'b0);
      send_sample(32'd2000, 1'b0);
      send_sample(32'd3000, 1'b0);
      send_sample(32'd500, 1'b1);
      // Starts high: a fall, then two rises where the later one wins; samples at the
      // threshold form no crossing.
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'd0, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'd1000, 1'b0);
      send_sample(32'd2000, 1'b0);
      send_sample(32'd999, 1'b0);
      send_sample(32'd1001, 1'b1);
      // Starting at the threshold counts as starting high.
      send_sample(32'd1000, 1'b0);
      send_sample(32'd0, 1'b0);
      send_sample(32'd5000, 1'b1);
      send_sample(32'd999, 1'b0);
      send_sample(32'd1001, 1'b0);
      send_sample(32'd999, 1'b0);
      send_sample(32'd1001, 1'b0);
      send_sample(32'd999, 1'b1);
      drain_block();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               thr = $urandom;
               zs  = 32'h0001_0000;
            end
            1: begin
               thr = $urandom;
               zs  = 32'h00FF_FFFF;
            end
            2: begin
               thr = 32'h0;
               zs  = $urandom;
            end
            3: begin
               thr = 32'hFFFF_FFFF;
               zs  = $urandom;
            end
            4: begin
               thr = $urandom_range(1, 64);
               zs  = 32'h0;
            end
            5: begin
               thr = $urandom;
               zs  = $urandom;
            end
            6: begin
               thr = 32'd1;
               zs  = 32'd1;
            end
            default: begin
               thr = 32'hFFFF_FFFF - $urandom_range(0, 64);
               zs  = $urandom;
            end
         endcase
         if (p == 7)
            calm = 1;
         apply_settings(thr, zs);
         // One column may run past the depth so the bin index pins at its top.
         if (p == 5)
            send_column($urandom_range(COLUMN_DEPTH - 1, COLUMN_DEPTH + 24));
         budget = (p == 2 || p == 3) ? 40 : 100;
         phase_start = samples_sent;
         while (samples_sent - phase_start < budget) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            send_column(len);
         end
         drain_block();
      end

      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/icc_pkg.sv
hw/rtl/icc_if.sv
hw/rtl/icc_csr.sv
hw/rtl/icc_front.sv
hw/rtl/icc_queue.sv
hw/rtl/icc_back.sv
hw/rtl/isodensity_column_crossing_core.sv
sim/tb.sv
